[hw/rtl/bale_pkg.sv]
// Shared types, sizes and codes of the bounded array list engine.
`default_nettype none

package bale_pkg;

  // List capacity and derived widths
  localparam int unsigned Depth  = 16;
  localparam int unsigned IdxW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;

  // Fixed field widths of the command and result channels
  localparam int unsigned CmdW   = 2;
  localparam int unsigned PosW   = 5;
  localparam int unsigned StatW  = 2;
  localparam int unsigned FoundW = 4;
  localparam int unsigned CountW = 5;

  // Common width for position against count comparisons
  localparam int unsigned CmpW   = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOCATE = 2'd2,
    CMD_SORTED = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BADPOS   = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  // What a list cell loads at the next edge
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_LEFT  = 2'd2,
    OP_RIGHT = 2'd3
  } cell_op_e;

endpackage

`default_nettype wire

[hw/rtl/bale_cell.sv]
// One list cell: holds an entry, compares it against the broadcast value.
`default_nettype none

module bale_cell (
  input  logic                                clk_i,
  input  bale_pkg::cell_op_e                  op_i,
  input  logic                                cmp_en_i,
  input  logic signed [bale_pkg::DataW-1:0]   value_i,
  input  logic signed [bale_pkg::DataW-1:0]   left_i,
  input  logic signed [bale_pkg::DataW-1:0]   right_i,
  output logic signed [bale_pkg::DataW-1:0]   entry_o,
  output logic                                eq_o,
  output logic                                gt_o
);
  import bale_pkg::*;

  logic signed [DataW-1:0] entry_q, entry_d;
  logic                    eq_q;
  logic                    gt_q;

  always_comb begin
    unique case (op_i)
      OP_HOLD:  entry_d = entry_q;
      OP_LOAD:  entry_d = value_i;
      OP_LEFT:  entry_d = left_i;
      OP_RIGHT: entry_d = right_i;
      default:  entry_d = entry_q;
    endcase
  end

  // Flags: entry equals the value, entry strictly greater than the value
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (cmp_en_i) begin
      eq_q <= (value_i == entry_q);
      gt_q <= (value_i < entry_q);
    end
  end

  assign entry_o = entry_q;
  assign eq_o    = eq_q;
  assign gt_o    = gt_q;

endmodule

`default_nettype wire

[hw/rtl/bounded_array_list_engine_top.sv]
// Top level of the bounded array list engine: command control and the row of list cells.
`default_nettype none

// Keeps an ordered list of up to 16 signed 32-bit entries in a row of cells and answers each
// command (insert at position, delete at position, locate, sorted insert) with one result
// carrying status, found index and the entry count after the command. At the transfer every
// cell registers how its entry compares with the value; in the execution state the flags
// are resolved and all cells shift or load at once. Execution waits while a previous result
// is still held on a stalled output, and no new command is accepted until it completes.
// Entry contents are not cleared by reset; only the count is, and entries at or beyond the
// count are never reported.

module bounded_array_list_engine_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bale_pkg::CmdW-1:0]     cmd_i,
  input  logic signed [bale_pkg::DataW-1:0] item_value_i,
  input  logic [bale_pkg::PosW-1:0]     item_position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bale_pkg::StatW-1:0]    status_o,
  output logic [bale_pkg::FoundW-1:0]   found_index_o,
  output logic [bale_pkg::CountW-1:0]   entry_count_o
);
  import bale_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                    state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [CmdW-1:0]         cmd_q;
  logic signed [DataW-1:0] val_q;
  logic [PosW-1:0]         pos_q;

  logic                    out_valid_q, out_valid_d;
  logic [StatW-1:0]        status_q, status_d;
  logic [FoundW-1:0]       found_q, found_d;
  logic [CountW-1:0]       out_count_q;

  logic                    in_xfer;
  logic                    fire;
  logic signed [DataW-1:0] cell_value;

  logic signed [DataW-1:0] entries [Depth];
  cell_op_e                ops     [Depth];
  logic [Depth-1:0]        eq_vec;
  logic [Depth-1:0]        gt_vec;
  logic [Depth-1:0]        live;
  logic [Depth-1:0]        hit_vec;
  logic [Depth-1:0]        big_vec;

  logic [IdxW-1:0]         last_hit;
  logic [CntW-1:0]         first_gt;
  logic                    do_ins;
  logic                    do_del;
  logic [CntW-1:0]         target;
  logic [CmpW-1:0]         pos_w;
  logic [CmpW-1:0]         cnt_w;
  logic                    full;

  assign in_stall_o = (state_q == ST_EXEC);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign fire       = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign cell_value = (state_q == ST_EXEC) ? val_q : item_value_i;

  assign pos_w = CmpW'(pos_q);
  assign cnt_w = CmpW'(count_q);
  assign full  = (count_q == CntW'(Depth));

  // Row of cells; each takes its left or right neighbour on a shift
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [DataW-1:0] left_n, right_n;

    if (i == 0) begin : g_first
      assign left_n = '0;
    end else begin : g_mid_l
      assign left_n = entries[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_n = '0;
    end else begin : g_mid_r
      assign right_n = entries[i+1];
    end

    assign live[i]    = (CntW'(i) < count_q);
    assign hit_vec[i] = live[i] && eq_vec[i];
    assign big_vec[i] = live[i] && gt_vec[i];

    always_comb begin
      ops[i] = OP_HOLD;
      if (fire && do_ins) begin
        if (CntW'(i) == target) begin
          ops[i] = OP_LOAD;
        end else if (CntW'(i) > target) begin
          ops[i] = OP_LEFT;
        end
      end else if (fire && do_del) begin
        if (CmpW'(i) >= pos_w) begin
          ops[i] = OP_RIGHT;
        end
      end
    end

    bale_cell u_cell (
      .clk_i    (clk_i),
      .op_i     (ops[i]),
      .cmp_en_i (in_xfer),
      .value_i  (cell_value),
      .left_i   (left_n),
      .right_i  (right_n),
      .entry_o  (entries[i]),
      .eq_o     (eq_vec[i]),
      .gt_o     (gt_vec[i])
    );
  end

  // Last matching cell and first greater cell among the live ones
  always_comb begin
    last_hit = '0;
    for (int i = 0; i < Depth; i++) begin
      if (hit_vec[i]) last_hit = IdxW'(i);
    end
  end

  always_comb begin
    first_gt = count_q;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (big_vec[i]) first_gt = CntW'(i);
    end
  end

  always_comb begin
    status_d = STAT_OK;
    found_d  = '0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    target   = first_gt;
    count_d  = count_q;
    unique case (cmd_e'(cmd_q))
      CMD_INSERT: begin
        target = CntW'(pos_q);
        if (full) begin
          status_d = STAT_FULL;
        end else if (pos_w > cnt_w) begin
          status_d = STAT_BADPOS;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos_w >= cnt_w) begin
          status_d = STAT_BADPOS;
        end else begin
          do_del = 1'b1;
        end
      end
      CMD_LOCATE: begin
        if (|hit_vec) begin
          found_d = FoundW'(last_hit);
        end else begin
          status_d = STAT_NOTFOUND;
        end
      end
      CMD_SORTED: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      default: status_d = STAT_OK;
    endcase
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_del) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_EXEC;
      ST_EXEC: if (fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result while the output is stalled
  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fire) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= cmd_i;
      val_q <= item_value_i;
      pos_q <= item_position_i;
    end
    if (fire) begin
      status_q    <= status_d;
      found_q     <= found_d;
      out_count_q <= CountW'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign entry_count_o = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count exceeds capacity");

  a_xfer_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_EXEC))
    else $error("accepted command did not enter execution");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> $stable(count_q))
    else $error("entry count changed with no command in execution");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && do_ins) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("successful insert did not grow the list by one");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_count_q == CountW'(count_q)))
    else $error("reported count differs from list count");

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench of the bounded array list engine: directed table and random commands, shadow list.
`timescale 1ns / 1ps

module tb;
  import bale_pkg::*;

  localparam int unsigned NumRandom   = 1600;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePct     = 19;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned NumDirected = 29;

  typedef struct packed {
    status_e           status;
    logic [FoundW-1:0] found;
    logic [CountW-1:0] count;
  } list_result_t;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         pos;
    logic                    typed;
    list_result_t            result;
  } stim_row_t;

  localparam list_result_t NoCheck = '{STAT_OK, 4'd0, 5'd0};

  // Typed results only where obvious; the rest go through the shadow list
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{CMD_DELETE, 32'sd0,          5'd0,  1'b1, '{STAT_BADPOS,   4'd0, 5'd0}},
    '{CMD_LOCATE, 32'sh7FFF_FFFF,  5'd0,  1'b1, '{STAT_NOTFOUND, 4'd0, 5'd0}},
    '{CMD_INSERT, 32'sd1,          5'd1,  1'b1, '{STAT_BADPOS,   4'd0, 5'd0}},
    '{CMD_SORTED, -32'sd5,         5'd0,  1'b1, '{STAT_OK,       4'd0, 5'd1}},
    '{CMD_INSERT, 32'sh8000_0000,  5'd0,  1'b1, '{STAT_OK,       4'd0, 5'd2}},
    '{CMD_INSERT, 32'sh7FFF_FFFF,  5'd2,  1'b1, '{STAT_OK,       4'd0, 5'd3}},
    '{CMD_SORTED, -32'sd5,         5'd0,  1'b0, NoCheck},
    '{CMD_LOCATE, -32'sd5,         5'd0,  1'b0, NoCheck},
    '{CMD_INSERT, 32'sd0,          5'd31, 1'b1, '{STAT_BADPOS,   4'd0, 5'd4}},
    '{CMD_DELETE, 32'sd0,          5'd31, 1'b1, '{STAT_BADPOS,   4'd0, 5'd4}},
    '{CMD_DELETE, 32'sd0,          5'd4,  1'b1, '{STAT_BADPOS,   4'd0, 5'd4}},
    '{CMD_DELETE, 32'sd0,          5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'sd1,          5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'shFFFF_FFFF,  5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'sh5555_5555,  5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'shAAAA_AAAA,  5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'sd100,        5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, -32'sd100,       5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'sd7,          5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'sd7,          5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'sd0,          5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'sh7FFF_FFFF,  5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'sh8000_0000,  5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'sd42,         5'd0,  1'b0, NoCheck},
    '{CMD_SORTED, 32'sd3,          5'd0,  1'b0, NoCheck},
    '{CMD_INSERT, 32'sd9,          5'd0,  1'b1, '{STAT_FULL,     4'd0, 5'd16}},
    '{CMD_SORTED, 32'sd0,          5'd0,  1'b1, '{STAT_FULL,     4'd0, 5'd16}},
    '{CMD_DELETE, 32'sd0,          5'd15, 1'b0, NoCheck},
    '{CMD_LOCATE, 32'sd12345,      5'd0,  1'b1, '{STAT_NOTFOUND, 4'd0, 5'd15}}
  };

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic [CmdW-1:0]         cmd_i           = CMD_INSERT;
  logic signed [DataW-1:0] item_value_i    = '0;
  logic [PosW-1:0]         item_position_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic [StatW-1:0]        status_o;
  logic [FoundW-1:0]       found_index_o;
  logic [CountW-1:0]       entry_count_o;

  // Shadow copy of the list
  logic signed [DataW-1:0] list_entries [Depth];
  int unsigned             list_fill = 0;
  list_result_t            pending_results [$];
  int unsigned             mismatch_count = 0;
  int unsigned             cycle_count = 0;
  logic                    steady = 1'b0;

  bounded_array_list_engine_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .item_value_i    (item_value_i),
    .item_position_i (item_position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_index_o   (found_index_o),
    .entry_count_o   (entry_count_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Apply one command to the shadow list and work out its result
  task automatic run_list_command(input cmd_e c, input logic signed [DataW-1:0] v,
                                  input logic [PosW-1:0] p, output list_result_t r);
    int unsigned at;
    r = NoCheck;
    case (c)
      CMD_INSERT, CMD_SORTED: begin
        at = (c == CMD_INSERT) ? p : list_fill;
        // Scan backwards so the first strictly greater entry wins
        if (c == CMD_SORTED)
          for (int i = int'(list_fill) - 1; i >= 0; i--)
            if (v < list_entries[i]) at = i;
        if (list_fill >= Depth) r.status = STAT_FULL;
        else if (at > list_fill) r.status = STAT_BADPOS;
        else begin
          for (int i = list_fill; i > at; i--) list_entries[i] = list_entries[i-1];
          list_entries[at] = v;
          list_fill++;
        end
      end
      CMD_DELETE: begin
        if (p >= list_fill) r.status = STAT_BADPOS;
        else begin
          for (int i = p; i + 1 < list_fill; i++) list_entries[i] = list_entries[i+1];
          list_fill--;
        end
      end
      default: begin
        r.status = STAT_NOTFOUND;
        for (int i = 0; i < list_fill; i++)
          if (list_entries[i] == v) begin
            r.status = STAT_OK;
            r.found  = FoundW'(i);
          end
      end
    endcase
    r.count = CountW'(list_fill);
  endtask

  // Drive one command, hold it until the transfer, then queue what it should give
  task automatic issue_command(input cmd_e c, input logic signed [DataW-1:0] v,
                               input logic [PosW-1:0] p, input logic typed,
                               input list_result_t typed_result);
    list_result_t r;
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= c;
    item_value_i    <= v;
    item_position_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    run_list_command(c, v, p, r);
    pending_results.push_back(typed ? typed_result : r);
  endtask

  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no command pending: status %0d, count %0d",
               status_o, entry_count_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (found_index_o !== want.found) begin
          $error("found_index: expected %0d, got %0d", want.found, found_index_o);
          mismatch_count++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          mismatch_count++;
        end
      end
    end
    out_stall_i <= !steady && ($urandom_range(99) < IdlePct);
  end

  initial begin : stimulus
    cmd_e                    c;
    logic signed [DataW-1:0] v;
    logic [PosW-1:0]         p;
    int unsigned             roll;
    logic                    draining;
    draining = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[k])
      issue_command(DirectedRows[k].cmd, DirectedRows[k].value, DirectedRows[k].pos,
                    DirectedRows[k].typed, DirectedRows[k].result);

    for (int n = 0; n < NumRandom; n++) begin
      steady = (n >= 700 && n < 1000);
      // Swing the list between empty and full so both ends are visited often
      if (list_fill == Depth) draining = 1'b1;
      else if (list_fill == 0) draining = 1'b0;
      else if ($urandom_range(99) < 2) draining = !draining;

      roll = $urandom_range(99);
      if (draining) begin
        if (roll < 15) c = CMD_INSERT;
        else if (roll < 25) c = CMD_SORTED;
        else if (roll < 70) c = CMD_DELETE;
        else c = CMD_LOCATE;
      end else begin
        if (roll < 35) c = CMD_INSERT;
        else if (roll < 60) c = CMD_SORTED;
        else if (roll < 75) c = CMD_DELETE;
        else c = CMD_LOCATE;
      end

      if ($urandom_range(99) < 85) p = PosW'($urandom_range(list_fill));
      else p = PosW'($urandom_range(31));

      roll = $urandom_range(99);
      if (roll < 40) v = $urandom;
      else if (roll < 70) v = int'($urandom_range(6)) - 3;
      else if (roll < 80) begin
        case ($urandom_range(3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end else if (list_fill > 0) v = list_entries[$urandom_range(list_fill - 1)];
      else v = $urandom;

      issue_command(c, v, p, 1'b0, NoCheck);
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
